>>> hdl/stereo_peak_compressor_core_defines.svh
// Assertion macros for the compressor core.
// They expect clk and rst_n in the scope of use.
`ifndef STEREO_PEAK_COMPRESSOR_CORE_DEFINES_SVH
`define STEREO_PEAK_COMPRESSOR_CORE_DEFINES_SVH

`define SPC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define SPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/spc_pkg.sv
package spc_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int GAIN_TABLE_BITS = 10;
    localparam int GAIN_W          = 17;
    localparam int CFG_W           = 23;
    localparam int CFG_IDX_W       = 3;
    localparam int RED_W           = 16;
    localparam int MUL_W           = 32;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int CHAIN_W         = 31;

    localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * SAMPLE_BITS + RED_W + 7) / 8) * 8;

    localparam logic [21:0] OCT_PER_UNIT_Q32 = 22'd2786635;
    localparam logic [14:0] NINE_TENTHS_Q15  = 15'd29491;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASTER_GAIN  = 3'd0,
        REG_GATE_LEVEL   = 3'd1,
        REG_MIN_GAIN_DB  = 3'd2,
        REG_ATTACK_STEP  = 3'd3,
        REG_RELEASE_STEP = 3'd4,
        REG_HOLD_FRAMES  = 3'd5,
        REG_METER_PERIOD = 3'd6,
        REG_METER_FALL   = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef logic [GAIN_TABLE_BITS-1:0][CHAIN_W-1:0] chain_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 factors 2^-(2^-k), k = 1..GAIN_TABLE_BITS
    function automatic chain_t sqrt_chain();
        chain_t      res;
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int k = 0; k < GAIN_TABLE_BITS; k++)
        begin
            c = isqrt64(c << 30);
            res[k] = c[CHAIN_W-1:0];
        end
        return res;
    endfunction

    localparam chain_t SQRT_CHAIN = sqrt_chain();

endpackage

>>> hdl/spc_mul.sv
module spc_mul
(
    input  logic                       clk,
    input  spc_pkg::mul_req_t          req,
    output logic [spc_pkg::PROD_W-1:0] prod
);

    logic [spc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

>>> hdl/stereo_peak_compressor_core.sv
// Stereo peak compressor with hold and falling peak meter. Each request on the
// s_ side is one stereo frame and yields exactly one request on the m_ side.
// A frame is accepted only once the sequencer has finished the previous one
// (s_tready is high only while the sequencer is idle); the pace is set by
// the single shared 32x32 multiplier, which forms 16 products per frame in
// turn: the dB-to-octave conversion, master gain times 0.9, ten steps of the
// 2^-f mantissa, and two products per channel. The result sits in an output
// register, so the next frame is taken while it waits; a stalled m_tready
// holds the sequencer in its final step only. Configuration writes take
// effect at once and belong between frames.
`include "stereo_peak_compressor_core_defines.svh"

module stereo_peak_compressor_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [spc_pkg::IN_DATA_W-1:0]        s_tdata,   // left_in, right_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [spc_pkg::OUT_DATA_W-1:0]       m_tdata,   // left_out, right_out,
                                                            // meter_left, meter_right,
                                                            // reduction_db
    output logic [0:0]                           m_tuser,   // meter_valid
    input  logic                                 cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spc_pkg::CFG_W-1:0]            cfg_data
);

    localparam int SB    = spc_pkg::SAMPLE_BITS;
    localparam int NB    = spc_pkg::GAIN_TABLE_BITS;
    localparam int GW    = spc_pkg::GAIN_W;
    localparam int K_W   = $clog2(NB);
    localparam int CW    = spc_pkg::CHAIN_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_OCT  = 11'b000_0000_0010,
        S_OCTR = 11'b000_0000_0100,
        S_G9R  = 11'b000_0000_1000,
        S_MMUL = 11'b000_0001_0000,
        S_MACC = 11'b000_0010_0000,
        S_MAG  = 11'b000_0100_0000,
        S_P1   = 11'b000_1000_0000,
        S_PMUL = 11'b001_0000_0000,
        S_SCL  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    // configuration
    logic [15:0]          master_gain_reg;
    logic [22:0]          gate_level_reg;
    logic signed [GW-1:0] min_gain_reg;
    logic [15:0]          attack_reg;
    logic [15:0]          release_reg;
    logic [15:0]          hold_frames_reg;
    logic [15:0]          meter_period_reg;
    logic [22:0]          meter_fall_reg;

    // control and state
    state_t               state_reg, state_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic                 ch_reg, ch_next;
    logic signed [GW-1:0] gain_db_reg, gain_db_next;
    logic [15:0]          hold_reg, hold_next;
    logic signed [SB-1:0] peak_l_reg, peak_l_next;
    logic signed [SB-1:0] peak_r_reg, peak_r_next;
    logic signed [SB-1:0] level_left_reg, level_left_next;
    logic signed [SB-1:0] level_right_reg, level_right_next;
    logic [15:0]          period_reg, period_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic signed [SB-1:0] in_l_reg, in_r_reg;
    logic [GW-1:0]        neg_reg;
    logic [22:0]          oct_reg;
    logic [30:0]          g9_reg;
    logic [CW-1:0]        m_reg;
    logic [NB-1:0]        idx_reg;
    logic [28:0]          mant_reg;
    logic [27:0]          p1_reg;
    logic signed [SB-1:0] lo_reg, ro_reg;
    logic signed [SB-1:0] out_l_reg, out_r_reg, out_ml_reg, out_mr_reg;
    logic [spc_pkg::RED_W-1:0] out_red_reg;
    logic                 out_mv_reg;

    spc_pkg::mul_req_t          mreq;
    logic [spc_pkg::PROD_W-1:0] prod;

    spc_mul u_mul
    (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    logic accept;
    logic fin_go;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == S_FIN) && (!out_valid_reg || m_tready);

    // ---------------- datapath pieces ----------------
    logic signed [SB-1:0] cur_s;
    logic [SB-1:0]        cur_mag;
    logic [63:0]          oct_sum, m_sum, p1_sum;
    logic [7:0]           shamt;
    logic [63:0]          shifted;
    logic [32:0]          rnd;
    logic [31:0]          r_mag, r_sat;
    logic signed [SB-1:0] scl_val;

    always_comb
    begin
        cur_s   = ch_reg ? in_r_reg : in_l_reg;
        cur_mag = cur_s[SB-1] ? (~cur_s + SB'(1)) : cur_s;
        oct_sum = prod + 64'd32768;
        m_sum   = prod + (64'd1 << 29);
        p1_sum  = prod + (64'd1 << 26);
        shamt   = 8'd27 + {1'b0, oct_reg[22:16]};
        shifted = prod >> shamt[5:0];
        rnd     = {1'b0, shifted[31:0]} + 33'd1;
        r_mag   = (shamt >= 8'd63) ? 32'd0 : rnd[32:1];
        if (cur_s[SB-1])
        begin
            r_sat   = (r_mag > (32'd1 << (SB - 1))) ? (32'd1 << (SB - 1)) : r_mag;
            scl_val = ~r_sat[SB-1:0] + SB'(1);
        end
        else
        begin
            r_sat   = (r_mag > ((32'd1 << (SB - 1)) - 32'd1)) ?
                      ((32'd1 << (SB - 1)) - 32'd1) : r_mag;
            scl_val = r_sat[SB-1:0];
        end
    end

    always_comb
    begin
        mreq = '0;
        unique case (state_reg)
            S_OCT:
            begin
                mreq.en = 1'b1;
                mreq.a  = 32'(neg_reg);
                mreq.b  = 32'(spc_pkg::OCT_PER_UNIT_Q32);
            end
            S_OCTR:
            begin
                mreq.en = 1'b1;
                mreq.a  = 32'(master_gain_reg);
                mreq.b  = 32'(spc_pkg::NINE_TENTHS_Q15);
            end
            S_MMUL:
            begin
                mreq.en = 1'b1;
                mreq.a  = 32'(m_reg);
                mreq.b  = 32'(spc_pkg::SQRT_CHAIN[k_reg]);
            end
            S_MAG:
            begin
                mreq.en = 1'b1;
                mreq.a  = 32'(cur_mag);
                mreq.b  = 32'(g9_reg);
            end
            S_PMUL:
            begin
                mreq.en = 1'b1;
                mreq.a  = 32'(p1_reg);
                mreq.b  = 32'(mant_reg);
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    // ---------------- frame close ----------------
    logic [SB-1:0]        abs_l, abs_r, dc;
    logic                 loud;
    logic signed [GW-1:0] minv;
    logic signed [GW+1:0] att, rel;
    logic signed [GW-1:0] gain_upd;
    logic signed [SB-1:0] pl_new, pr_new;
    logic signed [SB:0]   sub_l, sub_r;
    logic signed [SB-1:0] lvl_l_new, lvl_r_new;
    logic                 emit;
    logic [spc_pkg::RED_W-1:0] red;

    always_comb
    begin
        abs_l = lo_reg[SB-1] ? (~lo_reg + SB'(1)) : lo_reg;
        abs_r = ro_reg[SB-1] ? (~ro_reg + SB'(1)) : ro_reg;
        dc    = (abs_l > abs_r) ? abs_l : abs_r;
        loud  = dc > SB'(gate_level_reg);
        minv  = min_gain_reg[GW-1] ? min_gain_reg : '0;
        att   = (GW+2)'(gain_db_reg) - $signed({3'b000, attack_reg});
        rel   = (GW+2)'(gain_db_reg) + $signed({3'b000, release_reg});
        hold_next = hold_reg;
        priority if (loud)
        begin
            gain_upd  = (att < (GW+2)'(minv)) ? minv : att[GW-1:0];
            hold_next = hold_frames_reg;
        end
        else if (hold_reg != 16'd0)
        begin
            gain_upd  = gain_db_reg;
            hold_next = hold_reg - 16'd1;
        end
        else
        begin
            gain_upd = (rel > 0) ? '0 : rel[GW-1:0];
        end

        pl_new = (lo_reg > peak_l_reg) ? lo_reg : peak_l_reg;
        pr_new = (ro_reg > peak_r_reg) ? ro_reg : peak_r_reg;
        sub_l  = (SB+1)'(level_left_reg) - $signed({2'b00, meter_fall_reg});
        sub_r  = (SB+1)'(level_right_reg) - $signed({2'b00, meter_fall_reg});
        lvl_l_new = (sub_l < (SB+1)'(pl_new)) ? pl_new : sub_l[SB-1:0];
        lvl_r_new = (sub_r < (SB+1)'(pr_new)) ? pr_new : sub_r[SB-1:0];
        emit = (period_reg == 16'd0);
        red  = neg_reg[GW-1] ? '1 : neg_reg[spc_pkg::RED_W-1:0];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        ch_next          = ch_reg;
        gain_db_next     = gain_db_reg;
        peak_l_next      = peak_l_reg;
        peak_r_next      = peak_r_reg;
        level_left_next  = level_left_reg;
        level_right_next = level_right_reg;
        period_next      = period_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OCT;
                end
            end
            S_OCT:  state_next = S_OCTR;
            S_OCTR: state_next = S_G9R;
            S_G9R:
            begin
                k_next     = '0;
                state_next = S_MMUL;
            end
            S_MMUL: state_next = S_MACC;
            S_MACC:
            begin
                k_next = k_reg + K_W'(1);
                if (k_reg == K_W'(NB - 1))
                begin
                    ch_next    = 1'b0;
                    state_next = S_MAG;
                end
                else
                begin
                    state_next = S_MMUL;
                end
            end
            S_MAG:  state_next = S_P1;
            S_P1:   state_next = S_PMUL;
            S_PMUL: state_next = S_SCL;
            S_SCL:
            begin
                ch_next    = 1'b1;
                state_next = ch_reg ? S_FIN : S_MAG;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    gain_db_next   = gain_upd;
                    if (emit)
                    begin
                        period_next      = meter_period_reg;
                        level_left_next  = lvl_l_new;
                        level_right_next = lvl_r_new;
                        peak_l_next      = '0;
                        peak_r_next      = '0;
                    end
                    else
                    begin
                        period_next = period_reg - 16'd1;
                        peak_l_next = pl_new;
                        peak_r_next = pr_new;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            k_reg           <= '0;
            ch_reg          <= 1'b0;
            gain_db_reg     <= '0;
            hold_reg        <= '0;
            peak_l_reg      <= '0;
            peak_r_reg      <= '0;
            level_left_reg  <= '0;
            level_right_reg <= '0;
            period_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            ch_reg          <= ch_next;
            gain_db_reg     <= gain_db_next;
            if (fin_go)
            begin
                hold_reg <= hold_next;
            end
            peak_l_reg      <= peak_l_next;
            peak_r_reg      <= peak_r_next;
            level_left_reg  <= level_left_next;
            level_right_reg <= level_right_next;
            period_reg      <= period_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_gain_reg  <= 16'd4096;
            gate_level_reg   <= 23'd8388607;
            min_gain_reg     <= -17'sd38400;
            attack_reg       <= 16'd256;
            release_reg      <= 16'd16;
            hold_frames_reg  <= 16'd1200;
            meter_period_reg <= 16'd1023;
            meter_fall_reg   <= 23'd1024;
        end
        else if (cfg_we)
        begin
            unique case (spc_pkg::cfg_reg_e'(cfg_index))
                spc_pkg::REG_MASTER_GAIN:  master_gain_reg  <= cfg_data[15:0];
                spc_pkg::REG_GATE_LEVEL:   gate_level_reg   <= cfg_data[22:0];
                spc_pkg::REG_MIN_GAIN_DB:  min_gain_reg     <= cfg_data[GW-1:0];
                spc_pkg::REG_ATTACK_STEP:  attack_reg       <= cfg_data[15:0];
                spc_pkg::REG_RELEASE_STEP: release_reg      <= cfg_data[15:0];
                spc_pkg::REG_HOLD_FRAMES:  hold_frames_reg  <= cfg_data[15:0];
                spc_pkg::REG_METER_PERIOD: meter_period_reg <= cfg_data[15:0];
                spc_pkg::REG_METER_FALL:   meter_fall_reg   <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_l_reg <= s_tdata[SB-1:0];
            in_r_reg <= s_tdata[2*SB-1:SB];
            neg_reg  <= ~gain_db_reg + GW'(1);
            m_reg    <= CW'(1) << 30;
        end
        if (state_reg == S_OCTR)
        begin
            oct_reg <= oct_sum[38:16];
            idx_reg <= oct_sum[31:32-NB];
        end
        if (state_reg == S_G9R)
        begin
            g9_reg <= prod[30:0];
        end
        if (state_reg == S_MACC)
        begin
            if (idx_reg[NB-1])
            begin
                m_reg <= m_sum[60:30];
            end
            idx_reg <= {idx_reg[NB-2:0], 1'b0};
        end
        if (state_reg == S_MAG)
        begin
            mant_reg <= 29'((32'(m_reg) + 32'd2) >> 2);
        end
        if (state_reg == S_P1)
        begin
            p1_reg <= p1_sum[54:27];
        end
        if (state_reg == S_SCL)
        begin
            if (ch_reg)
            begin
                ro_reg <= scl_val;
            end
            else
            begin
                lo_reg <= scl_val;
            end
        end
        if (fin_go)
        begin
            out_l_reg   <= lo_reg;
            out_r_reg   <= ro_reg;
            out_mv_reg  <= emit;
            out_ml_reg  <= emit ? lvl_l_new : '0;
            out_mr_reg  <= emit ? lvl_r_new : '0;
            out_red_reg <= emit ? red : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_mv_reg;
    assign m_tdata  = spc_pkg::OUT_DATA_W'({out_red_reg, out_mr_reg, out_ml_reg,
                                            out_r_reg, out_l_reg});

    `SPC_ASSERT_NEXT(a_accept_starts, accept, state_reg == S_OCT)
    `SPC_ASSERT_ALWAYS(a_gain_nonpos, gain_db_reg[GW-1] || (gain_db_reg == '0))
    `SPC_ASSERT_ALWAYS(a_level_nonneg, !level_left_reg[SB-1] && !level_right_reg[SB-1])
    `SPC_ASSERT_NEXT(a_fin_stall, (state_reg == S_FIN) && out_valid_reg && !m_tready,
                     state_reg == S_FIN)

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam logic [63:0] DB_TO_OCT_Q32 = 64'd2786635;
    localparam logic [63:0] GAIN_09_Q15   = 64'd29491;
    localparam int          MANT_ENTRIES  = 1 << GAIN_TABLE_BITS;
    localparam int          RAND_PHASES   = 8;
    localparam int          RAND_PER_PHASE = 104;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_out;
        logic [SAMPLE_BITS-1:0] right_out;
        logic                   meter_valid;
        logic [SAMPLE_BITS-1:0] meter_left;
        logic [SAMPLE_BITS-1:0] meter_right;
        logic [RED_W-1:0]       reduction_db;
    } frame_result_t;

    typedef struct {
        bit [15:0] master_gain;
        bit [22:0] gate_level;
        bit [16:0] min_gain_db;
        bit [15:0] attack_step;
        bit [15:0] release_step;
        bit [15:0] hold_frames;
        bit [15:0] meter_period;
        bit [22:0] meter_fall;
    } comp_settings_t;

    class compressor_scoreboard;
        bit [15:0]       master_gain;
        bit [22:0]       gate_level;
        bit [16:0]       min_gain_db;
        bit [15:0]       attack_step;
        bit [15:0]       release_step;
        bit [15:0]       hold_frames;
        bit [15:0]       meter_period;
        bit [22:0]       meter_fall;
        longint          gain_db;
        int unsigned     hold_count;
        int unsigned     period_count;
        longint          peak_left;
        longint          peak_right;
        longint          level_left;
        longint          level_right;
        bit [63:0]       mant_tab [MANT_ENTRIES];
        frame_result_t   expected_frames [$];
        int              mismatches;

        function new();
            bit [63:0] roots [GAIN_TABLE_BITS];
            bit [63:0] c;
            bit [63:0] m;
            // 2^-(2^-k) in Q30, then every 2^-f mantissa in Q28
            c = 64'd1 << 29;
            for (int k = 0; k < GAIN_TABLE_BITS; k++)
            begin
                c = floor_sqrt(c << 30);
                roots[k] = c;
            end
            for (int i = 0; i < MANT_ENTRIES; i++)
            begin
                m = 64'd1 << 30;
                for (int k = 0; k < GAIN_TABLE_BITS; k++)
                begin
                    if (i[GAIN_TABLE_BITS-1-k])
                        m = (m * roots[k] + (64'd1 << 29)) >> 30;
                end
                mant_tab[i] = (m + 64'd2) >> 2;
            end
            master_gain  = 16'd4096;
            gate_level   = 23'h7FFFFF;
            min_gain_db  = 17'(-38400);
            attack_step  = 16'd256;
            release_step = 16'd16;
            hold_frames  = 16'd1200;
            meter_period = 16'd1023;
            meter_fall   = 23'd1024;
            gain_db      = 0;
            hold_count   = 0;
            period_count = 0;
            peak_left    = 0;
            peak_right   = 0;
            level_left   = 0;
            level_right  = 0;
            mismatches   = 0;
        endfunction

        function bit [63:0] floor_sqrt(bit [63:0] x);
            bit [63:0] root;
            bit [63:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x)
                    root = trial;
            end
            return root;
        endfunction

        function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_MASTER_GAIN:  master_gain  = v[15:0];
                REG_GATE_LEVEL:   gate_level   = v[22:0];
                REG_MIN_GAIN_DB:  min_gain_db  = v[16:0];
                REG_ATTACK_STEP:  attack_step  = v[15:0];
                REG_RELEASE_STEP: release_step = v[15:0];
                REG_HOLD_FRAMES:  hold_frames  = v[15:0];
                REG_METER_PERIOD: meter_period = v[15:0];
                REG_METER_FALL:   meter_fall   = v[22:0];
                default: ;
            endcase
        endfunction

        function longint scale_sample(logic [SAMPLE_BITS-1:0] s, bit [63:0] mant,
                                      int unsigned sh);
            longint    sv;
            bit [63:0] mag;
            bit [63:0] p1;
            bit [63:0] p;
            bit [63:0] r;
            bit [63:0] lim;
            sv  = longint'($signed(s));
            mag = (sv < 0) ? -sv : sv;
            p1  = (mag * master_gain * GAIN_09_Q15 + (64'd1 << 26)) >> 27;
            p   = p1 * mant;
            r   = (sh >= 64) ? 64'd0 : (p + (64'd1 << (sh - 1))) >> sh;
            lim = 64'd1 << (SAMPLE_BITS - 1);
            if (sv < 0)
            begin
                if (r > lim)
                    r = lim;
                return -longint'(r);
            end
            if (r > lim - 1)
                r = lim - 1;
            return longint'(r);
        endfunction

        function void note_frame(logic [SAMPLE_BITS-1:0] l_in, logic [SAMPLE_BITS-1:0] r_in);
            frame_result_t want;
            longint        neg;
            longint        lo;
            longint        ro;
            longint        minv;
            longint        g;
            bit [63:0]     oct;
            bit [63:0]     al;
            bit [63:0]     ar;
            bit [63:0]     loudest;
            int unsigned   sh;
            neg = -gain_db;
            oct = (64'(neg) * DB_TO_OCT_Q32 + 64'd32768) >> 16;
            sh  = 28 + int'(oct >> 16);
            lo  = scale_sample(l_in, mant_tab[oct[15 -: GAIN_TABLE_BITS]], sh);
            ro  = scale_sample(r_in, mant_tab[oct[15 -: GAIN_TABLE_BITS]], sh);
            al  = (lo < 0) ? -lo : lo;
            ar  = (ro < 0) ? -ro : ro;
            loudest = (al > ar) ? al : ar;

            // gain follows the frame's scaled level; positive floor acts as 0 dB
            minv = longint'($signed(min_gain_db));
            if (minv > 0)
                minv = 0;
            if (loudest > gate_level)
            begin
                g = gain_db - longint'(attack_step);
                if (g < minv)
                    g = minv;
                gain_db    = g;
                hold_count = hold_frames;
            end
            else if (hold_count > 0)
            begin
                hold_count--;
            end
            else
            begin
                g = gain_db + longint'(release_step);
                if (g > 0)
                    g = 0;
                gain_db = g;
            end

            if (lo > peak_left)
                peak_left = lo;
            if (ro > peak_right)
                peak_right = ro;

            want = '0;
            want.left_out  = lo[SAMPLE_BITS-1:0];
            want.right_out = ro[SAMPLE_BITS-1:0];
            if (period_count == 0)
            begin
                period_count = meter_period;
                level_left  -= longint'(meter_fall);
                level_right -= longint'(meter_fall);
                if (level_left < peak_left)
                    level_left = peak_left;
                if (level_right < peak_right)
                    level_right = peak_right;
                peak_left  = 0;
                peak_right = 0;
                want.meter_valid  = 1'b1;
                want.meter_left   = level_left[SAMPLE_BITS-1:0];
                want.meter_right  = level_right[SAMPLE_BITS-1:0];
                want.reduction_db = (neg > 65535) ? 16'hFFFF : neg[15:0];
            end
            else
            begin
                period_count--;
            end
            expected_frames.push_back(want);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("mismatch on %s: got %h, want %h", what, got, want);
        endtask

        task check_frame(logic [OUT_DATA_W-1:0] d, logic [0:0] u);
            frame_result_t want;
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected frame", d[63:0], '0);
                return;
            end
            want = expected_frames.pop_front();
            if (d[23:0] !== want.left_out)
                report_mismatch("left_out", d[23:0], want.left_out);
            if (d[47:24] !== want.right_out)
                report_mismatch("right_out", d[47:24], want.right_out);
            if (u[0] !== want.meter_valid)
                report_mismatch("meter_valid", u[0], want.meter_valid);
            if (d[71:48] !== want.meter_left)
                report_mismatch("meter_left", d[71:48], want.meter_left);
            if (d[95:72] !== want.meter_right)
                report_mismatch("meter_right", d[95:72], want.meter_right);
            if (d[111:96] !== want.reduction_db)
                report_mismatch("reduction_db", d[111:96], want.reduction_db);
        endtask

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int src_idle_pct;
    int snk_stall_pct;

    compressor_scoreboard sb = new();

    stereo_peak_compressor_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // result side: check, then pick next cycle's tready
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_frame(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task send_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_frame(l, r);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0 || s_tready !== 1'b1);
    endtask

    task write_one(cfg_reg_e idx, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task apply_settings(comp_settings_t st);
        write_one(REG_MASTER_GAIN,  CFG_W'(st.master_gain));
        write_one(REG_GATE_LEVEL,   CFG_W'(st.gate_level));
        write_one(REG_MIN_GAIN_DB,  CFG_W'(st.min_gain_db));
        write_one(REG_ATTACK_STEP,  CFG_W'(st.attack_step));
        write_one(REG_RELEASE_STEP, CFG_W'(st.release_step));
        write_one(REG_HOLD_FRAMES,  CFG_W'(st.hold_frames));
        write_one(REG_METER_PERIOD, CFG_W'(st.meter_period));
        write_one(REG_METER_FALL,   CFG_W'(st.meter_fall));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] make_sample(bit loud);
        logic [SAMPLE_BITS-1:0] mag;
        int                     pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return SAMPLE_BITS'($urandom);
        if (pick == 1)
            return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        if (loud)
            mag = SAMPLE_BITS'($urandom_range(23'h7FFFFF, 23'h1FFFFF));
        else
            mag = SAMPLE_BITS'($urandom_range(23'h7FFFFF) >> $urandom_range(23, 4));
        return $urandom_range(1) ? -mag : mag;
    endfunction

    initial
    begin
        comp_settings_t st;
        int             sent;
        int             seg_len;
        bit             loud;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MASTER_GAIN;
        cfg_data      = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings; first frame emits the meter
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'hFFFFFF, 24'h000001);
        send_frame(24'h7FFFFF, 24'h7FFFFF);

        // upper extremes: saturation, fast attack to the floor, instant release
        wait_drained();
        st = '{16'd65535, 23'd0, 17'(-38400), 16'd38400, 16'd38400, 16'd0, 16'd0,
               23'h7FFFFF};
        apply_settings(st);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h800000);
        send_frame(24'h000001, 24'hFFFFFF);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h7FFFFF);

        // floor above 0 dB clamps to 0 dB; long hold and meter period
        wait_drained();
        st = '{16'd65535, 23'd0, 17'd100, 16'd256, 16'd0, 16'd65535, 16'd65535, 23'd0};
        apply_settings(st);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h400000, 24'hC00000);
        send_frame(24'h000000, 24'h000000);

        // most negative floor: reduction saturates
        wait_drained();
        st = '{16'd65535, 23'd0, 17'h10000, 16'd38400, 16'd0, 16'd0, 16'd0, 23'd1024};
        apply_settings(st);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h000000, 24'h000000);

        // zero master gain, release from the bottom
        wait_drained();
        st = '{16'd0, 23'h7FFFFF, 17'd0, 16'd0, 16'd38400, 16'd0, 16'd1, 23'd1024};
        apply_settings(st);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h000000, 24'h000000);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            case (ph % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 67;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 67;
                end
                default:
                begin
                    src_idle_pct  = 17;
                    snk_stall_pct = 17;
                end
            endcase
            case ($urandom_range(3))
                0:       st.master_gain = 16'd4096;
                1:       st.master_gain = 16'($urandom);
                2:       st.master_gain = 16'($urandom_range(8192, 1024));
                default: st.master_gain = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            st.gate_level   = 23'($urandom_range(23'h7FFFFF) >> $urandom_range(8));
            st.min_gain_db  = 17'(-int'($urandom_range(38400)));
            st.attack_step  = 16'($urandom_range(38400) >> $urandom_range(10));
            st.release_step = 16'($urandom_range(38400) >> $urandom_range(12));
            st.hold_frames  = ($urandom_range(7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(20));
            st.meter_period = ($urandom_range(7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(15));
            st.meter_fall   = 23'($urandom_range(23'h7FFFFF) >> $urandom_range(22));
            apply_settings(st);

            // loud bursts and quiet stretches drive attack, hold and release
            sent = 0;
            while (sent < RAND_PER_PHASE)
            begin
                loud    = $urandom_range(1);
                seg_len = loud ? $urandom_range(30, 1) : $urandom_range(40, 1);
                for (int j = 0; j < seg_len && sent < RAND_PER_PHASE; j++)
                begin
                    send_frame(make_sample(loud), make_sample(loud));
                    sent++;
                    if (ph == 1 && sent == RAND_PER_PHASE / 2)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spc_pkg.sv
hdl/spc_mul.sv
hdl/stereo_peak_compressor_core.sv
tb/tb_top.sv
